// ===== rtl/aff_pkg.sv =====
// Shared types and constants for the 2D affine point transform.
// Used by every module of the block; depends on nothing.
package aff_pkg;

  localparam int CFG_W         = 32;
  localparam int CFG_IDX_W     = 3;
  localparam int COORD_W_DEF   = 16;
  localparam int FRAC_W_DEF    = 16;
  localparam int PROD_W        = 2 * CFG_W;
  localparam int DMAG_W        = 2 * CFG_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_XX  = 3'd0,
    REG_COEF_XY  = 3'd1,
    REG_COEF_YX  = 3'd2,
    REG_COEF_YY  = 3'd3,
    REG_OFFSET_X = 3'd4,
    REG_OFFSET_Y = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    OP_FWD = 1'b0,
    OP_INV = 1'b1
  } op_e;

  typedef struct packed {
    logic valid;
    logic last;
    logic inv;
    logic fault;
  } aff_meta_t;

endpackage

// ===== rtl/affine_point_transform_2d.sv =====
// Top level of the 2D affine point transform: configuration registers and pipeline.
// Depends on aff_pkg, aff_mul, aff_sum and aff_div.
//
// One point enters per clock unless stalled; its result passes through the stages
// (product stage, sum stage, sign stage, range check, one divider stage per output
// bit, round-and-saturate stage). The whole pipeline advances together; a stalled
// output word freezes it, so in_stall_o follows out_stall_i while the output holds
// a word. Write the registers only while no point is in flight.
module affine_point_transform_2d import aff_pkg::*; #(
  parameter int COORD_WIDTH   = COORD_W_DEF,
  parameter int FRACTION_BITS = FRAC_W_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          op_i,
  input  logic signed [COORD_WIDTH-1:0] x_in_i,
  input  logic signed [COORD_WIDTH-1:0] y_in_i,
  input  logic                          last_point_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [COORD_WIDTH-1:0] x_out_o,
  output logic signed [COORD_WIDTH-1:0] y_out_o,
  output logic                          divide_fault_o,
  output logic                          last_result_o,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_W-1:0]              cfg_data_i
);

  localparam int PCW   = COORD_WIDTH + CFG_W;
  localparam int NUM_W = ((PCW + FRACTION_BITS + 1 > 2 * CFG_W + 1)
                          ? PCW + FRACTION_BITS + 1 : 2 * CFG_W + 1) + 1;

  logic signed [CFG_W-1:0] coef_xx_q, coef_xy_q, coef_yx_q, coef_yy_q;
  logic signed [CFG_W-1:0] offset_x_q, offset_y_q;
  logic adv;

  aff_meta_t in_meta, m1_meta, m2_meta, out_meta;
  logic signed [PCW-1:0]    p_x_xx, p_x_xy, p_x_yy, p_y_xx, p_y_yx, p_y_yy;
  logic signed [PROD_W-1:0] p_xx_oy, p_xy_ox, p_yy_ox, p_yx_oy, p_det_a, p_det_b;
  logic signed [NUM_W-1:0]  num_x, num_y;
  logic signed [DMAG_W:0]   den;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_xx_q  <= CFG_W'(1) << FRACTION_BITS;
      coef_xy_q  <= '0;
      coef_yx_q  <= '0;
      coef_yy_q  <= CFG_W'(1) << FRACTION_BITS;
      offset_x_q <= '0;
      offset_y_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_COEF_XX:  coef_xx_q  <= cfg_data_i;
        REG_COEF_XY:  coef_xy_q  <= cfg_data_i;
        REG_COEF_YX:  coef_yx_q  <= cfg_data_i;
        REG_COEF_YY:  coef_yy_q  <= cfg_data_i;
        REG_OFFSET_X: offset_x_q <= cfg_data_i;
        REG_OFFSET_Y: offset_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign adv        = !out_meta.valid || !out_stall_i;
  assign in_stall_o = !adv;

  always_comb begin
    in_meta       = '0;
    in_meta.valid = in_valid_i;
    in_meta.last  = last_point_i;
    in_meta.inv   = (op_e'(op_i) == OP_INV);
  end

  aff_mul #(.COORD_WIDTH(COORD_WIDTH)) u_mul (
    .clk_i, .rst_ni, .adv_i(adv), .meta_i(in_meta),
    .x_i(x_in_i), .y_i(y_in_i),
    .coef_xx_i(coef_xx_q), .coef_xy_i(coef_xy_q), .coef_yx_i(coef_yx_q),
    .coef_yy_i(coef_yy_q), .offset_x_i(offset_x_q), .offset_y_i(offset_y_q),
    .meta_o(m1_meta),
    .p_x_xx_o(p_x_xx), .p_x_xy_o(p_x_xy), .p_x_yy_o(p_x_yy),
    .p_y_xx_o(p_y_xx), .p_y_yx_o(p_y_yx), .p_y_yy_o(p_y_yy),
    .p_xx_oy_o(p_xx_oy), .p_xy_ox_o(p_xy_ox), .p_yy_ox_o(p_yy_ox),
    .p_yx_oy_o(p_yx_oy), .p_det_a_o(p_det_a), .p_det_b_o(p_det_b)
  );

  aff_sum #(
    .COORD_WIDTH(COORD_WIDTH), .FRACTION_BITS(FRACTION_BITS), .NUM_W(NUM_W)
  ) u_sum (
    .clk_i, .rst_ni, .adv_i(adv), .meta_i(m1_meta),
    .p_x_xx_i(p_x_xx), .p_x_xy_i(p_x_xy), .p_x_yy_i(p_x_yy),
    .p_y_xx_i(p_y_xx), .p_y_yx_i(p_y_yx), .p_y_yy_i(p_y_yy),
    .p_xx_oy_i(p_xx_oy), .p_xy_ox_i(p_xy_ox), .p_yy_ox_i(p_yy_ox),
    .p_yx_oy_i(p_yx_oy), .p_det_a_i(p_det_a), .p_det_b_i(p_det_b),
    .coef_xx_i(coef_xx_q), .offset_x_i(offset_x_q), .offset_y_i(offset_y_q),
    .meta_o(m2_meta), .num_x_o(num_x), .num_y_o(num_y), .den_o(den)
  );

  aff_div #(.COORD_WIDTH(COORD_WIDTH), .NUM_W(NUM_W)) u_div_x (
    .clk_i, .rst_ni, .adv_i(adv), .meta_i(m2_meta),
    .num_i(num_x), .den_i(den), .meta_o(out_meta), .res_o(x_out_o)
  );

  aff_div #(.COORD_WIDTH(COORD_WIDTH), .NUM_W(NUM_W)) u_div_y (
    .clk_i, .rst_ni, .adv_i(adv), .meta_i(m2_meta),
    .num_i(num_y), .den_i(den), .meta_o(), .res_o(y_out_o)
  );

  assign out_valid_o    = out_meta.valid;
  assign divide_fault_o = out_meta.fault;
  assign last_result_o  = out_meta.last;

endmodule

// ===== rtl/aff_mul.sv =====
// Product stage: all coordinate, offset and determinant products, registered.
// Depends on aff_pkg.
module aff_mul import aff_pkg::*; #(
  parameter int COORD_WIDTH = COORD_W_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 adv_i,
  input  aff_meta_t                            meta_i,
  input  logic signed [COORD_WIDTH-1:0]        x_i,
  input  logic signed [COORD_WIDTH-1:0]        y_i,
  input  logic signed [CFG_W-1:0]              coef_xx_i,
  input  logic signed [CFG_W-1:0]              coef_xy_i,
  input  logic signed [CFG_W-1:0]              coef_yx_i,
  input  logic signed [CFG_W-1:0]              coef_yy_i,
  input  logic signed [CFG_W-1:0]              offset_x_i,
  input  logic signed [CFG_W-1:0]              offset_y_i,
  output aff_meta_t                            meta_o,
  output logic signed [COORD_WIDTH+CFG_W-1:0]  p_x_xx_o,
  output logic signed [COORD_WIDTH+CFG_W-1:0]  p_x_xy_o,
  output logic signed [COORD_WIDTH+CFG_W-1:0]  p_x_yy_o,
  output logic signed [COORD_WIDTH+CFG_W-1:0]  p_y_xx_o,
  output logic signed [COORD_WIDTH+CFG_W-1:0]  p_y_yx_o,
  output logic signed [COORD_WIDTH+CFG_W-1:0]  p_y_yy_o,
  output logic signed [PROD_W-1:0]             p_xx_oy_o,
  output logic signed [PROD_W-1:0]             p_xy_ox_o,
  output logic signed [PROD_W-1:0]             p_yy_ox_o,
  output logic signed [PROD_W-1:0]             p_yx_oy_o,
  output logic signed [PROD_W-1:0]             p_det_a_o,
  output logic signed [PROD_W-1:0]             p_det_b_o
);

  localparam int PCW = COORD_WIDTH + CFG_W;

  aff_meta_t meta_q;
  logic signed [PCW-1:0]    p_x_xx_q, p_x_xy_q, p_x_yy_q, p_y_xx_q, p_y_yx_q, p_y_yy_q;
  logic signed [PROD_W-1:0] p_xx_oy_q, p_xy_ox_q, p_yy_ox_q, p_yx_oy_q, p_det_a_q, p_det_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_q <= '0;
    end else if (adv_i) begin
      meta_q <= meta_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p_x_xx_q  <= PCW'(x_i) * PCW'(coef_xx_i);
      p_x_xy_q  <= PCW'(x_i) * PCW'(coef_xy_i);
      p_x_yy_q  <= PCW'(x_i) * PCW'(coef_yy_i);
      p_y_xx_q  <= PCW'(y_i) * PCW'(coef_xx_i);
      p_y_yx_q  <= PCW'(y_i) * PCW'(coef_yx_i);
      p_y_yy_q  <= PCW'(y_i) * PCW'(coef_yy_i);
      p_xx_oy_q <= PROD_W'(coef_xx_i) * PROD_W'(offset_y_i);
      p_xy_ox_q <= PROD_W'(coef_xy_i) * PROD_W'(offset_x_i);
      p_yy_ox_q <= PROD_W'(coef_yy_i) * PROD_W'(offset_x_i);
      p_yx_oy_q <= PROD_W'(coef_yx_i) * PROD_W'(offset_y_i);
      p_det_a_q <= PROD_W'(coef_xx_i) * PROD_W'(coef_yy_i);
      p_det_b_q <= PROD_W'(coef_xy_i) * PROD_W'(coef_yx_i);
    end
  end

  assign meta_o    = meta_q;
  assign p_x_xx_o  = p_x_xx_q;
  assign p_x_xy_o  = p_x_xy_q;
  assign p_x_yy_o  = p_x_yy_q;
  assign p_y_xx_o  = p_y_xx_q;
  assign p_y_yx_o  = p_y_yx_q;
  assign p_y_yy_o  = p_y_yy_q;
  assign p_xx_oy_o = p_xx_oy_q;
  assign p_xy_ox_o = p_xy_ox_q;
  assign p_yy_ox_o = p_yy_ox_q;
  assign p_yx_oy_o = p_yx_oy_q;
  assign p_det_a_o = p_det_a_q;
  assign p_det_b_o = p_det_b_q;

endmodule

// ===== rtl/aff_sum.sv =====
// Sum stage: numerators, divisor, and the inverse-direction divide fault.
// Depends on aff_pkg.
module aff_sum import aff_pkg::*; #(
  parameter int COORD_WIDTH   = COORD_W_DEF,
  parameter int FRACTION_BITS = FRAC_W_DEF,
  parameter int NUM_W         = 2 * CFG_W + 2
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                adv_i,
  input  aff_meta_t                           meta_i,
  input  logic signed [COORD_WIDTH+CFG_W-1:0] p_x_xx_i,
  input  logic signed [COORD_WIDTH+CFG_W-1:0] p_x_xy_i,
  input  logic signed [COORD_WIDTH+CFG_W-1:0] p_x_yy_i,
  input  logic signed [COORD_WIDTH+CFG_W-1:0] p_y_xx_i,
  input  logic signed [COORD_WIDTH+CFG_W-1:0] p_y_yx_i,
  input  logic signed [COORD_WIDTH+CFG_W-1:0] p_y_yy_i,
  input  logic signed [PROD_W-1:0]            p_xx_oy_i,
  input  logic signed [PROD_W-1:0]            p_xy_ox_i,
  input  logic signed [PROD_W-1:0]            p_yy_ox_i,
  input  logic signed [PROD_W-1:0]            p_yx_oy_i,
  input  logic signed [PROD_W-1:0]            p_det_a_i,
  input  logic signed [PROD_W-1:0]            p_det_b_i,
  input  logic signed [CFG_W-1:0]             coef_xx_i,
  input  logic signed [CFG_W-1:0]             offset_x_i,
  input  logic signed [CFG_W-1:0]             offset_y_i,
  output aff_meta_t                           meta_o,
  output logic signed [NUM_W-1:0]             num_x_o,
  output logic signed [NUM_W-1:0]             num_y_o,
  output logic signed [DMAG_W:0]              den_o
);

  localparam int DETW = DMAG_W + 1;

  logic signed [NUM_W-1:0] fwd_x, fwd_y, inv_x, inv_y;
  logic signed [DETW-1:0]  det;
  logic                    fault;
  aff_meta_t               meta_d, meta_q;
  logic signed [NUM_W-1:0] num_x_d, num_y_d, num_x_q, num_y_q;
  logic signed [DETW-1:0]  den_d, den_q;

  always_comb begin
    fwd_x = NUM_W'(p_x_xx_i) + NUM_W'(p_y_yx_i) + NUM_W'(offset_x_i);
    fwd_y = NUM_W'(p_x_xy_i) + NUM_W'(p_y_yy_i) + NUM_W'(offset_y_i);
    inv_y = ((NUM_W'(p_y_xx_i) - NUM_W'(p_x_xy_i)) <<< FRACTION_BITS)
            - (NUM_W'(p_xx_oy_i) - NUM_W'(p_xy_ox_i));
    inv_x = ((NUM_W'(p_x_yy_i) - NUM_W'(p_y_yx_i)) <<< FRACTION_BITS)
            - (NUM_W'(p_yy_ox_i) - NUM_W'(p_yx_oy_i));
    det   = DETW'(p_det_a_i) - DETW'(p_det_b_i);
    fault = meta_i.inv && ((det == '0) || (coef_xx_i == '0));

    meta_d       = meta_i;
    meta_d.fault = fault;
    if (fault) begin
      num_x_d = '0;
      num_y_d = '0;
      den_d   = DETW'(1);
    end else if (meta_i.inv) begin
      num_x_d = inv_x;
      num_y_d = inv_y;
      den_d   = det;
    end else begin
      num_x_d = fwd_x;
      num_y_d = fwd_y;
      den_d   = DETW'(1) <<< FRACTION_BITS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_q <= '0;
    end else if (adv_i) begin
      meta_q <= meta_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      num_x_q <= num_x_d;
      num_y_q <= num_y_d;
      den_q   <= den_d;
    end
  end

  assign meta_o  = meta_q;
  assign num_x_o = num_x_q;
  assign num_y_o = num_y_q;
  assign den_o   = den_q;

endmodule

// ===== rtl/aff_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, then round and saturate.
// Depends on aff_pkg.
module aff_div import aff_pkg::*; #(
  parameter int COORD_WIDTH = COORD_W_DEF,
  parameter int NUM_W       = 2 * CFG_W + 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  aff_meta_t                     meta_i,
  input  logic signed [NUM_W-1:0]       num_i,
  input  logic signed [DMAG_W:0]        den_i,
  output aff_meta_t                     meta_o,
  output logic signed [COORD_WIDTH-1:0] res_o
);

  localparam int RW = ((NUM_W > DMAG_W + COORD_WIDTH) ? NUM_W : DMAG_W + COORD_WIDTH) + 1;
  localparam int QW = COORD_WIDTH + 1;

  logic [NUM_W-1:0]  num_abs;
  logic [DMAG_W-1:0] den_abs;
  aff_meta_t         a_meta_q;
  logic [NUM_W-1:0]  a_num_q;
  logic [DMAG_W-1:0] a_den_q;
  logic              a_neg_q;

  aff_meta_t         s_meta_q [COORD_WIDTH+1];
  logic [RW-1:0]     s_rem_q  [COORD_WIDTH+1];
  logic [DMAG_W-1:0] s_den_q  [COORD_WIDTH+1];
  logic              s_neg_q  [COORD_WIDTH+1];
  logic              s_ovf_q  [COORD_WIDTH+1];
  logic [COORD_WIDTH-1:0] s_quo_q [COORD_WIDTH+1];

  logic              rnd, sat;
  logic [QW-1:0]     q_rnd, limit, mag;
  logic [QW-1:0]     res_full;
  aff_meta_t         o_meta_q;
  logic [COORD_WIDTH-1:0] res_q;

  always_comb begin
    num_abs = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
    den_abs = den_i[DMAG_W] ? DMAG_W'(-den_i) : DMAG_W'(den_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_meta_q    <= '0;
      s_meta_q[0] <= '0;
    end else if (adv_i) begin
      a_meta_q    <= meta_i;
      s_meta_q[0] <= a_meta_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_num_q    <= num_abs;
      a_den_q    <= den_abs;
      a_neg_q    <= num_i[NUM_W-1] ^ den_i[DMAG_W];
      s_rem_q[0] <= RW'(a_num_q);
      s_den_q[0] <= a_den_q;
      s_neg_q[0] <= a_neg_q;
      s_ovf_q[0] <= RW'(a_num_q) >= (RW'(a_den_q) << COORD_WIDTH);
      s_quo_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < COORD_WIDTH; k++) begin : g_stage
    logic [RW-1:0] trial;
    logic          ge;

    always_comb begin
      trial = RW'(s_den_q[k]) << (COORD_WIDTH - 1 - k);
      ge    = s_rem_q[k] >= trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        s_meta_q[k+1] <= '0;
      end else if (adv_i) begin
        s_meta_q[k+1] <= s_meta_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        s_rem_q[k+1] <= ge ? (s_rem_q[k] - trial) : s_rem_q[k];
        s_quo_q[k+1] <= {s_quo_q[k][COORD_WIDTH-2:0], ge};
        s_den_q[k+1] <= s_den_q[k];
        s_neg_q[k+1] <= s_neg_q[k];
        s_ovf_q[k+1] <= s_ovf_q[k];
      end
    end
  end

  always_comb begin
    rnd   = {s_rem_q[COORD_WIDTH], 1'b0} >= (RW+1)'(s_den_q[COORD_WIDTH]);
    q_rnd = QW'(s_quo_q[COORD_WIDTH]) + QW'(rnd);
    limit = s_neg_q[COORD_WIDTH] ? (QW'(1) << (COORD_WIDTH - 1))
                                 : ((QW'(1) << (COORD_WIDTH - 1)) - QW'(1));
    sat   = s_ovf_q[COORD_WIDTH] || (q_rnd > limit);
    mag   = sat ? limit : q_rnd;
    res_full = s_neg_q[COORD_WIDTH] ? (QW'(0) - mag) : mag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_meta_q <= '0;
    end else if (adv_i) begin
      o_meta_q <= s_meta_q[COORD_WIDTH];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      res_q <= res_full[COORD_WIDTH-1:0];
    end
  end

  assign meta_o = o_meta_q;
  assign res_o  = res_q;

endmodule

// ===== rtl/aff_checker.sv =====
// Port-level checks for the affine point transform, bound to the top level.
// Depends on aff_pkg and affine_point_transform_2d.
module aff_checker import aff_pkg::*; #(
  parameter int COORD_WIDTH = COORD_W_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [COORD_WIDTH-1:0] x_out_o,
  input logic [COORD_WIDTH-1:0] y_out_o,
  input logic                   divide_fault_o,
  input logic                   last_result_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(x_out_o) && $stable(y_out_o)
      && $stable(divide_fault_o) && $stable(last_result_o))
    else $error("stalled output word changed");

  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_fault_o |-> (x_out_o == '0) && (y_out_o == '0))
    else $error("faulted word carries a nonzero point");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

endmodule

bind affine_point_transform_2d aff_checker #(.COORD_WIDTH(COORD_WIDTH)) u_aff_checker (.*);
